// ===== design/qvr_pkg.sv =====
// Shared constants for the quaternion vector rotation core.
// No dependencies; used by the core and its divider.
`timescale 1ns / 1ps

package qvr_pkg;

    // Stages of the product and sum datapath ahead of the divider.
    localparam int MathStages = 4;

    // Divider stages around the per-bit chain: magnitude, range check, round.
    localparam int DivPreStages  = 2;
    localparam int DivPostStages = 1;

endpackage

// ===== design/qvr_req_if.sv =====
// Input channel of the quaternion vector rotation core.
// Carries one quaternion and one vector per item; no dependencies.
`timescale 1ns / 1ps

interface qvr_req_if #(
    parameter int QUAT_WIDTH = 16,
    parameter int VEC_WIDTH  = 24
) ();
    logic                         valid;
    logic                         ready;
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
    logic signed [VEC_WIDTH-1:0]  vec_x;
    logic signed [VEC_WIDTH-1:0]  vec_y;
    logic signed [VEC_WIDTH-1:0]  vec_z;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        input  ready
    );
    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        output ready
    );
endinterface

// ===== design/qvr_rsp_if.sv =====
// Output channel of the quaternion vector rotation core.
// Carries one rotated vector and its flags per item; no dependencies.
`timescale 1ns / 1ps

interface qvr_rsp_if #(
    parameter int VEC_WIDTH = 24
) ();
    logic                        valid;
    logic                        ready;
    logic signed [VEC_WIDTH-1:0] rot_x;
    logic signed [VEC_WIDTH-1:0] rot_y;
    logic signed [VEC_WIDTH-1:0] rot_z;
    logic                        saturated;
    logic                        zero_quat;

    modport source (
        output valid, rot_x, rot_y, rot_z, saturated, zero_quat,
        input  ready
    );
    modport sink (
        input  valid, rot_x, rot_y, rot_z, saturated, zero_quat,
        output ready
    );
endinterface

// ===== design/quaternion_vector_rotation_core.sv =====
// Top level of the quaternion vector rotation core: q * (0,v) * q^-1.
// Depends on qvr_pkg, qvr_req_if, qvr_rsp_if and qvr_divider.
//
// The core takes one item per clock while the output is not stalled and returns one
// item per item, in order. The depth is set by the divider, which resolves one
// quotient bit per stage for all three components at once; the products and sums
// ahead of it take four stages. The whole pipeline advances whenever the output stage
// is empty or taken, so ready on the input follows ready on the output. Results are
// rounded to nearest, ties away from zero, and saturated; a quaternion of zero norm
// returns zeros with zero_quat set.
`timescale 1ns / 1ps

module quaternion_vector_rotation_core #(
    parameter int QUAT_WIDTH = 16,
    parameter int VEC_WIDTH  = 24
) (
    input  logic     clk,
    input  logic     rst_n,
    qvr_req_if.sink  req,
    qvr_rsp_if.source rsp
);
    import qvr_pkg::*;

    localparam int QW    = QUAT_WIDTH;
    localparam int VW    = VEC_WIDTH;
    localparam int SQW   = 2 * QW;
    localparam int PW    = QW + VW;
    localparam int SW    = 2 * QW + 2;
    localparam int N_W   = 2 * QW + 1;
    localparam int DW    = PW + 2;
    localparam int CW    = PW + 1;
    localparam int SXW   = SW + VW;
    localparam int DBW   = DW + QW;
    localparam int ACW   = QW + CW;
    localparam int MAG_W = 2 * QW + VW + 5;
    localparam int LAT   = MathStages + DivPreStages + VW + DivPostStages;
    localparam int ZQN   = LAT - 2;

    logic en;
    logic v_reg [LAT];
    logic zq_reg [ZQN];

    // Stage 1: squares and pairwise products.
    logic signed [SQW-1:0] sq_w_reg, sq_x_reg, sq_y_reg, sq_z_reg;
    logic signed [PW-1:0]  p_bx_reg, p_cy_reg, p_dz_reg;
    logic signed [PW-1:0]  p_cz_reg, p_dy_reg, p_dx_reg, p_bz_reg, p_by_reg, p_cx_reg;
    logic signed [QW-1:0]  a1_reg, b1_reg, c1_reg, d1_reg;
    logic signed [VW-1:0]  x1_reg, y1_reg, z1_reg;

    // Stage 2: norm, scalar term, dot and cross products.
    logic        [N_W-1:0] n2_reg;
    logic signed [SW-1:0]  s2_reg;
    logic signed [DW-1:0]  dot2_reg;
    logic signed [CW-1:0]  crx2_reg, cry2_reg, crz2_reg;
    logic signed [QW-1:0]  a2_reg, b2_reg, c2_reg, d2_reg;
    logic signed [VW-1:0]  x2_reg, y2_reg, z2_reg;
    logic signed [SW-1:0]  n_sum;

    // Stage 3: the nine wide products.
    logic        [N_W-1:0] n3_reg;
    logic signed [SXW-1:0] sx3_reg, sy3_reg, sz3_reg;
    logic signed [DBW-1:0] db3_reg, dc3_reg, dd3_reg;
    logic signed [ACW-1:0] acx3_reg, acy3_reg, acz3_reg;

    // Stage 4: numerators.
    logic        [N_W-1:0]   n4_reg;
    logic signed [MAG_W-1:0] nx4_reg, ny4_reg, nz4_reg;

    logic signed [VW-1:0] qx, qy, qz;
    logic                 satx, saty, satz;

    assign en        = !v_reg[LAT-1] || rsp.ready;
    assign req.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= req.valid;
            for (int i = 1; i < LAT; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_w_reg <= SQW'(req.quat_w) * SQW'(req.quat_w);
            sq_x_reg <= SQW'(req.quat_x) * SQW'(req.quat_x);
            sq_y_reg <= SQW'(req.quat_y) * SQW'(req.quat_y);
            sq_z_reg <= SQW'(req.quat_z) * SQW'(req.quat_z);
            p_bx_reg <= PW'(req.quat_x) * PW'(req.vec_x);
            p_cy_reg <= PW'(req.quat_y) * PW'(req.vec_y);
            p_dz_reg <= PW'(req.quat_z) * PW'(req.vec_z);
            p_cz_reg <= PW'(req.quat_y) * PW'(req.vec_z);
            p_dy_reg <= PW'(req.quat_z) * PW'(req.vec_y);
            p_dx_reg <= PW'(req.quat_z) * PW'(req.vec_x);
            p_bz_reg <= PW'(req.quat_x) * PW'(req.vec_z);
            p_by_reg <= PW'(req.quat_x) * PW'(req.vec_y);
            p_cx_reg <= PW'(req.quat_y) * PW'(req.vec_x);
            a1_reg   <= req.quat_w;
            b1_reg   <= req.quat_x;
            c1_reg   <= req.quat_y;
            d1_reg   <= req.quat_z;
            x1_reg   <= req.vec_x;
            y1_reg   <= req.vec_y;
            z1_reg   <= req.vec_z;
        end
    end

    assign n_sum = SW'(sq_w_reg) + SW'(sq_x_reg) + SW'(sq_y_reg) + SW'(sq_z_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg   <= n_sum[N_W-1:0];
            s2_reg   <= SW'(sq_w_reg) - SW'(sq_x_reg) - SW'(sq_y_reg) - SW'(sq_z_reg);
            dot2_reg <= DW'(p_bx_reg) + DW'(p_cy_reg) + DW'(p_dz_reg);
            crx2_reg <= CW'(p_cz_reg) - CW'(p_dy_reg);
            cry2_reg <= CW'(p_dx_reg) - CW'(p_bz_reg);
            crz2_reg <= CW'(p_by_reg) - CW'(p_cx_reg);
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            c2_reg   <= c1_reg;
            d2_reg   <= d1_reg;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            z2_reg   <= z1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n3_reg   <= n2_reg;
            sx3_reg  <= SXW'(s2_reg) * SXW'(x2_reg);
            sy3_reg  <= SXW'(s2_reg) * SXW'(y2_reg);
            sz3_reg  <= SXW'(s2_reg) * SXW'(z2_reg);
            db3_reg  <= DBW'(dot2_reg) * DBW'(b2_reg);
            dc3_reg  <= DBW'(dot2_reg) * DBW'(c2_reg);
            dd3_reg  <= DBW'(dot2_reg) * DBW'(d2_reg);
            acx3_reg <= ACW'(a2_reg) * ACW'(crx2_reg);
            acy3_reg <= ACW'(a2_reg) * ACW'(cry2_reg);
            acz3_reg <= ACW'(a2_reg) * ACW'(crz2_reg);
        end
    end

    // The dot and cross terms both carry a factor of two.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n4_reg  <= n3_reg;
            nx4_reg <= MAG_W'(sx3_reg) + (MAG_W'(db3_reg) <<< 1) + (MAG_W'(acx3_reg) <<< 1);
            ny4_reg <= MAG_W'(sy3_reg) + (MAG_W'(dc3_reg) <<< 1) + (MAG_W'(acy3_reg) <<< 1);
            nz4_reg <= MAG_W'(sz3_reg) + (MAG_W'(dd3_reg) <<< 1) + (MAG_W'(acz3_reg) <<< 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zq_reg[0] <= (n2_reg == '0);
            for (int i = 1; i < ZQN; i++)
            begin
                zq_reg[i] <= zq_reg[i-1];
            end
        end
    end

    qvr_divider #(.VEC_WIDTH(VW), .N_W(N_W), .MAG_W(MAG_W)) u_div_x (
        .clk(clk), .en(en), .num(nx4_reg), .norm(n4_reg), .quot(qx), .sat(satx)
    );
    qvr_divider #(.VEC_WIDTH(VW), .N_W(N_W), .MAG_W(MAG_W)) u_div_y (
        .clk(clk), .en(en), .num(ny4_reg), .norm(n4_reg), .quot(qy), .sat(saty)
    );
    qvr_divider #(.VEC_WIDTH(VW), .N_W(N_W), .MAG_W(MAG_W)) u_div_z (
        .clk(clk), .en(en), .num(nz4_reg), .norm(n4_reg), .quot(qz), .sat(satz)
    );

    assign rsp.valid     = v_reg[LAT-1];
    assign rsp.zero_quat = zq_reg[ZQN-1];
    assign rsp.rot_x     = zq_reg[ZQN-1] ? '0 : qx;
    assign rsp.rot_y     = zq_reg[ZQN-1] ? '0 : qy;
    assign rsp.rot_z     = zq_reg[ZQN-1] ? '0 : qz;
    assign rsp.saturated = !zq_reg[ZQN-1] && (satx || saty || satz);
endmodule

// ===== design/qvr_divider.sv =====
// Pipelined restoring divider with round-half-away and saturation.
// One quotient bit per stage; depends on qvr_pkg.
`timescale 1ns / 1ps

module qvr_divider #(
    parameter int VEC_WIDTH = 24,
    parameter int N_W       = 33,
    parameter int MAG_W     = 61
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [MAG_W-1:0]     num,
    input  logic        [N_W-1:0]       norm,
    output logic signed [VEC_WIDTH-1:0] quot,
    output logic                        sat
);
    import qvr_pkg::*;

    localparam int R_W = N_W + VEC_WIDTH;
    localparam logic [VEC_WIDTH:0] HALF = (VEC_WIDTH+1)'(1) << (VEC_WIDTH - 1);

    logic             neg_a_reg;
    logic [MAG_W-1:0] mag_a_reg;
    logic [N_W-1:0]   n_a_reg;

    logic                 neg_s_reg [VEC_WIDTH+1];
    logic                 ovf_s_reg [VEC_WIDTH+1];
    logic [N_W-1:0]       n_s_reg   [VEC_WIDTH+1];
    logic [R_W-1:0]       rem_s_reg [VEC_WIDTH+1];
    logic [VEC_WIDTH-1:0] q_s_reg   [VEC_WIDTH+1];

    logic signed [VEC_WIDTH-1:0] quot_reg;
    logic                        sat_reg;

    logic [MAG_W-1:0] lim_b;
    logic [R_W-1:0]   rem_f;
    logic [N_W-1:0]   n_f;
    logic             up_f;
    logic [VEC_WIDTH:0] qr_f;
    logic             sat_next;
    logic signed [VEC_WIDTH-1:0] quot_next;

    function automatic logic [MAG_W-1:0] norm_shift(input logic [N_W-1:0] n);
        norm_shift = MAG_W'(n) << VEC_WIDTH;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg <= num[MAG_W-1];
            mag_a_reg <= num[MAG_W-1] ? MAG_W'(-num) : MAG_W'(num);
            n_a_reg   <= norm;
        end
    end

    assign lim_b = MAG_W'(norm_shift(n_a_reg));

    // The range check makes the remainder fit R_W bits for the bit chain.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_s_reg[0] <= neg_a_reg;
            ovf_s_reg[0] <= (mag_a_reg >= lim_b);
            n_s_reg[0]   <= n_a_reg;
            rem_s_reg[0] <= mag_a_reg[R_W-1:0];
            q_s_reg[0]   <= '0;
        end
    end

    for (genvar i = 0; i < VEC_WIDTH; i++)
    begin : g_bit
        localparam int K = VEC_WIDTH - 1 - i;
        logic [R_W-1:0] dsh;
        logic           take;

        assign dsh  = R_W'(n_s_reg[i]) << K;
        assign take = (rem_s_reg[i] >= dsh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_s_reg[i+1] <= neg_s_reg[i];
                ovf_s_reg[i+1] <= ovf_s_reg[i];
                n_s_reg[i+1]   <= n_s_reg[i];
                rem_s_reg[i+1] <= take ? rem_s_reg[i] - dsh : rem_s_reg[i];
                q_s_reg[i+1]   <= q_s_reg[i] | (take ? (VEC_WIDTH'(1) << K) : '0);
            end
        end
    end

    always_comb
    begin
        rem_f = rem_s_reg[VEC_WIDTH];
        n_f   = n_s_reg[VEC_WIDTH];
        up_f  = (rem_f[N_W-1:0] >= (n_f - rem_f[N_W-1:0]));
        qr_f  = {1'b0, q_s_reg[VEC_WIDTH]} + (VEC_WIDTH+1)'(up_f);
        if (neg_s_reg[VEC_WIDTH])
        begin
            sat_next  = ovf_s_reg[VEC_WIDTH] || (qr_f > HALF);
            quot_next = sat_next ? VEC_WIDTH'(-HALF) : VEC_WIDTH'(-qr_f);
        end
        else
        begin
            sat_next  = ovf_s_reg[VEC_WIDTH] || (qr_f > HALF - 1'b1);
            quot_next = sat_next ? VEC_WIDTH'(HALF - 1'b1) : VEC_WIDTH'(qr_f);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= quot_next;
            sat_reg  <= sat_next;
        end
    end

    assign quot = quot_reg;
    assign sat  = sat_reg;

    // Total depth, checked here at elaboration.
    localparam int Depth = DivPreStages + VEC_WIDTH + DivPostStages;
    if (Depth != VEC_WIDTH + 3)
    begin : g_depth_bad
        $error("divider depth mismatch");
    end
endmodule

// ===== design/qvr_checker.sv =====
// Port-level assertions for the quaternion vector rotation core, with its bind.
// Depends on quaternion_vector_rotation_core and its channel interfaces.
`timescale 1ns / 1ps

module qvr_checker #(
    parameter int VEC_WIDTH = 24
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic signed [VEC_WIDTH-1:0] rot_x,
    input logic signed [VEC_WIDTH-1:0] rot_y,
    input logic signed [VEC_WIDTH-1:0] rot_z,
    input logic                        saturated,
    input logic                        zero_quat
);
    localparam logic signed [VEC_WIDTH-1:0] MaxV = {1'b0, {(VEC_WIDTH-1){1'b1}}};
    localparam logic signed [VEC_WIDTH-1:0] MinV = {1'b1, {(VEC_WIDTH-1){1'b0}}};

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rot_x) && $stable(rot_y)
            && $stable(rot_z) && $stable(saturated) && $stable(zero_quat))
        else $error("stalled result changed");

    // The pipeline never refuses an item while the output side drains.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ready |-> req_ready)
        else $error("input stalled with output ready");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && zero_quat |-> rot_x == '0 && rot_y == '0 && rot_z == '0 && !saturated)
        else $error("zero quaternion result not cleared");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && saturated |-> rot_x == MaxV || rot_x == MinV || rot_y == MaxV
            || rot_y == MinV || rot_z == MaxV || rot_z == MinV)
        else $error("saturated flag without a clipped component");
endmodule

bind quaternion_vector_rotation_core qvr_checker #(.VEC_WIDTH(VEC_WIDTH)) u_qvr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rot_x     (rsp.rot_x),
    .rot_y     (rsp.rot_y),
    .rot_z     (rsp.rot_z),
    .saturated (rsp.saturated),
    .zero_quat (rsp.zero_quat)
);
